// ----- rtl/min_max_fifo_unit_macros.svh -----
// Assertion macros for the min/max FIFO RTL.
`ifndef MIN_MAX_FIFO_UNIT_MACROS_SVH
`define MIN_MAX_FIFO_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define MMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mmf_pkg.sv -----
// Package for the min/max FIFO: sizes, request and error codes, cell types.
package mmf_pkg;

    localparam int DEPTH      = 256;
    localparam int VALUE_BITS = 31;
    localparam int SLOT_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int WIDE_BITS  = VALUE_BITS + 1;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // One queue entry held by a FIFO cell.
    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] value;
    } ent_t;

    // One min or max candidate: value plus the ring slot of its entry.
    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] value;
        logic [SLOT_BITS-1:0]  slot;
    } cand_t;

    // Broadcast to every FIFO cell.
    typedef struct packed {
        logic                  push;
        logic                  shift;
        logic [VALUE_BITS-1:0] x;
    } fifo_ctl_t;

    // Broadcast to every candidate cell of one deque.
    typedef struct packed {
        logic                  push;
        logic                  shift;
        logic [VALUE_BITS-1:0] x;
        logic [SLOT_BITS-1:0]  slot;
    } cand_ctl_t;

endpackage

// ----- rtl/mmf_ifs.sv -----
// Valid/ready channel interfaces for requests and results.
interface mmf_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [mmf_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface mmf_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mmf_pkg::WIDE_BITS-1:0] front_value;
    logic [mmf_pkg::VALUE_BITS-1:0]       min_value;
    logic signed [mmf_pkg::WIDE_BITS-1:0] max_value;
    logic                                 is_empty;
    logic [mmf_pkg::COUNT_BITS-1:0]       entry_count;
    logic [1:0]                           error_code;

    modport source (output valid, output front_value, output min_value, output max_value,
                    output is_empty, output entry_count, output error_code, input ready);
    modport sink   (input valid, input front_value, input min_value, input max_value,
                    input is_empty, input entry_count, input error_code, output ready);
endinterface

// ----- rtl/mmf_fifo_cell.sv -----
// FIFO cell: one queue entry; fills at the first empty cell, shifts toward the head on pop.
module mmf_fifo_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mmf_pkg::fifo_ctl_t ctl,
    input  logic               prev_valid,
    input  mmf_pkg::ent_t      right,
    output mmf_pkg::ent_t      state_q,
    output mmf_pkg::ent_t      state_d
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [mmf_pkg::VALUE_BITS-1:0] value_reg;
    logic [mmf_pkg::VALUE_BITS-1:0] value_next;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctl.shift)
        begin
            valid_next = right.valid;
            value_next = right.value;
        end
        else if (ctl.push)
        begin
            // first empty cell after a full one takes the new value
            valid_next = valid_reg | prev_valid;
            value_next = valid_reg ? value_reg : ctl.x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign state_q = '{valid: valid_reg, value: value_reg};
    assign state_d = '{valid: valid_next, value: value_next};

endmodule

// ----- rtl/mmf_cand_cell.sv -----
// Candidate cell of a monotonic deque: drops itself when the new value beats it.
module mmf_cand_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mmf_pkg::cand_ctl_t ctl,
    input  logic               keep_low,
    input  logic               prev_keep,
    input  mmf_pkg::cand_t     right,
    output logic               keep,
    output mmf_pkg::cand_t     state_q,
    output mmf_pkg::cand_t     state_d
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [mmf_pkg::VALUE_BITS-1:0] value_reg;
    logic [mmf_pkg::VALUE_BITS-1:0] value_next;
    logic [mmf_pkg::SLOT_BITS-1:0]  slot_reg;
    logic [mmf_pkg::SLOT_BITS-1:0]  slot_next;
    logic                           worse;

    // strictly worse only, so equal candidates stay in arrival order
    assign worse = keep_low ? (value_reg > ctl.x) : (value_reg < ctl.x);
    assign keep  = valid_reg && !worse;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        slot_next  = slot_reg;
        if (ctl.shift)
        begin
            valid_next = right.valid;
            value_next = right.value;
            slot_next  = right.slot;
        end
        else if (ctl.push)
        begin
            // deque is sorted, so kept cells form a prefix; the first
            // dropped or empty cell becomes the new tail
            valid_next = keep | prev_keep;
            value_next = keep ? value_reg : ctl.x;
            slot_next  = keep ? slot_reg : ctl.slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        slot_reg  <= slot_next;
    end

    assign state_q = '{valid: valid_reg, value: value_reg, slot: slot_reg};
    assign state_d = '{valid: valid_next, value: value_next, slot: slot_next};

endmodule

// ----- rtl/min_max_fifo_unit.sv -----
// Top level: FIFO with running minimum and maximum, built from rows of cells.
// A request's result sits in the output register in the cycle after acceptance.
// One request per cycle unless stalled; every cell compares the pushed value in parallel.
// A stalled result holds the output register; a new request is taken when it drains.
// Reset (rst_n low, async) clears cell valid bits, the fill count and slot pointers.
// No clearing pass: the block takes requests from the first cycle after reset.
`include "min_max_fifo_unit_macros.svh"

module min_max_fifo_unit (
    input  logic       clk,
    input  logic       rst_n,
    mmf_req_if.sink    req_ch,
    mmf_rsp_if.source  rsp_ch
);

    localparam int D = mmf_pkg::DEPTH;

    // ---------------------------------------------------------------
    // Pointers and fill count
    // ---------------------------------------------------------------
    logic [mmf_pkg::COUNT_BITS-1:0] count_reg;
    logic [mmf_pkg::COUNT_BITS-1:0] count_next;
    logic [mmf_pkg::SLOT_BITS-1:0]  read_slot_reg;
    logic [mmf_pkg::SLOT_BITS-1:0]  read_slot_next;
    logic [mmf_pkg::SLOT_BITS-1:0]  write_slot_reg;
    logic [mmf_pkg::SLOT_BITS-1:0]  write_slot_next;

    // Output register
    logic                                 rsp_valid_reg;
    logic signed [mmf_pkg::WIDE_BITS-1:0] front_reg;
    logic [mmf_pkg::VALUE_BITS-1:0]       min_reg;
    logic signed [mmf_pkg::WIDE_BITS-1:0] max_reg;
    logic                                 empty_reg;
    logic [mmf_pkg::COUNT_BITS-1:0]       entry_count_reg;
    logic [1:0]                           err_reg;

    logic       accept;
    logic       do_push;
    logic       do_pop;
    logic       full;
    logic       empty_now;
    logic       min_hit;
    logic       max_hit;
    logic [1:0] err_next;

    mmf_pkg::fifo_ctl_t fifo_ctl;
    mmf_pkg::cand_ctl_t min_ctl;
    mmf_pkg::cand_ctl_t max_ctl;

    // Cell state, one extra slot past the tail feeds an empty neighbor in.
    mmf_pkg::ent_t  fifo_q [D+1];
    mmf_pkg::ent_t  fifo_d [D];
    mmf_pkg::cand_t min_q  [D+1];
    mmf_pkg::cand_t min_d  [D];
    mmf_pkg::cand_t max_q  [D+1];
    mmf_pkg::cand_t max_d  [D];
    logic           fifo_prev [D+1];
    logic           min_keep  [D+1];
    logic           max_keep  [D+1];

    // The output register parts the two sides: take a request whenever it is
    // empty or being drained this cycle.
    assign req_ch.ready = !rsp_valid_reg || rsp_ch.ready;
    assign accept       = req_ch.valid && req_ch.ready;

    assign full      = (count_reg == mmf_pkg::COUNT_BITS'(D));
    assign empty_now = (count_reg == '0);

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    always_comb
    begin
        do_push  = 1'b0;
        do_pop   = 1'b0;
        err_next = mmf_pkg::ERR_OK;
        unique case (req_ch.req_type)
            mmf_pkg::REQ_PUSH:
            begin
                if (full)
                    err_next = mmf_pkg::ERR_FULL;
                else
                    do_push = accept;
            end
            mmf_pkg::REQ_POP:
            begin
                if (empty_now)
                    err_next = mmf_pkg::ERR_EMPTY;
                else
                    do_pop = accept;
            end
            default:
            begin
                // query, and the unused code behaves as a query
                err_next = mmf_pkg::ERR_OK;
            end
        endcase
    end

    // A departing entry leaves a deque only when it heads that deque.
    assign min_hit = min_q[0].valid && (min_q[0].slot == read_slot_reg);
    assign max_hit = max_q[0].valid && (max_q[0].slot == read_slot_reg);

    assign fifo_ctl = '{push: do_push, shift: do_pop, x: req_ch.value};
    assign min_ctl  = '{push: do_push, shift: do_pop && min_hit,
                        x: req_ch.value, slot: write_slot_reg};
    assign max_ctl  = '{push: do_push, shift: do_pop && max_hit,
                        x: req_ch.value, slot: write_slot_reg};

    always_comb
    begin
        count_next      = count_reg;
        read_slot_next  = read_slot_reg;
        write_slot_next = write_slot_reg;
        if (do_push)
        begin
            count_next      = count_reg + 1'b1;
            write_slot_next = (write_slot_reg == mmf_pkg::SLOT_BITS'(D - 1)) ?
                              '0 : write_slot_reg + 1'b1;
        end
        else if (do_pop)
        begin
            count_next     = count_reg - 1'b1;
            read_slot_next = (read_slot_reg == mmf_pkg::SLOT_BITS'(D - 1)) ?
                             '0 : read_slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            read_slot_reg  <= '0;
            write_slot_reg <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            read_slot_reg  <= read_slot_next;
            write_slot_reg <= write_slot_next;
        end
    end

    // ---------------------------------------------------------------
    // Cell rows: entries, min deque (non-decreasing), max deque (non-increasing)
    // ---------------------------------------------------------------
    assign fifo_prev[0] = 1'b1;
    assign min_keep[0]  = 1'b1;
    assign max_keep[0]  = 1'b1;
    assign fifo_q[D]    = '{valid: 1'b0, value: '0};
    assign min_q[D]     = '{valid: 1'b0, value: '0, slot: '0};
    assign max_q[D]     = '{valid: 1'b0, value: '0, slot: '0};

    for (genvar i = 0; i < D; i++)
    begin : g_row
        mmf_fifo_cell u_fifo (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (fifo_ctl),
            .prev_valid (fifo_prev[i]),
            .right      (fifo_q[i+1]),
            .state_q    (fifo_q[i]),
            .state_d    (fifo_d[i])
        );
        assign fifo_prev[i+1] = fifo_q[i].valid;

        mmf_cand_cell u_min (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (min_ctl),
            .keep_low  (1'b1),
            .prev_keep (min_keep[i]),
            .right     (min_q[i+1]),
            .keep      (min_keep[i+1]),
            .state_q   (min_q[i]),
            .state_d   (min_d[i])
        );

        mmf_cand_cell u_max (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (max_ctl),
            .keep_low  (1'b0),
            .prev_keep (max_keep[i]),
            .right     (max_q[i+1]),
            .keep      (max_keep[i+1]),
            .state_q   (max_q[i]),
            .state_d   (max_d[i])
        );
    end

    // ---------------------------------------------------------------
    // Result register, loaded from the heads' next state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ch.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_count_reg <= count_next;
            err_reg         <= err_next;
            if (count_next == '0)
            begin
                empty_reg <= 1'b1;
                front_reg <= '1;
                min_reg   <= '1;
                max_reg   <= {1'b1, {mmf_pkg::VALUE_BITS{1'b0}}};
            end
            else
            begin
                empty_reg <= 1'b0;
                front_reg <= {1'b0, fifo_d[0].value};
                min_reg   <= min_d[0].value;
                max_reg   <= {1'b0, max_d[0].value};
            end
        end
    end

    assign rsp_ch.valid       = rsp_valid_reg;
    assign rsp_ch.front_value = front_reg;
    assign rsp_ch.min_value   = min_reg;
    assign rsp_ch.max_value   = max_reg;
    assign rsp_ch.is_empty    = empty_reg;
    assign rsp_ch.entry_count = entry_count_reg;
    assign rsp_ch.error_code  = err_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // an empty queue leaves no live entry or candidate at the heads
    `MMF_ASSERT_NOW(a_empty_heads, count_reg == '0, !fifo_q[0].valid && !min_q[0].valid && !max_q[0].valid, "empty queue with live head cell")
    // every non-empty queue has a min and a max candidate
    `MMF_ASSERT_NOW(a_cand_present, count_reg != '0, min_q[0].valid && max_q[0].valid && fifo_q[0].valid, "non-empty queue without candidates")
    // a push that fits grows the count by one
    `MMF_ASSERT_NEXT(a_push_count, accept && req_ch.req_type == mmf_pkg::REQ_PUSH && !full, count_reg == $past(count_reg) + 1'b1, "push did not grow count")

endmodule
